/* rtl/hufd_pkg.sv */
// Shared types and constants of the Huffman tree-walk decoder.
// Depends on nothing; the controller, datapath, top level and testbench import it.
package hufd_pkg;

	localparam int NODE_W          = 9;
	localparam int NODE_DEPTH      = 512;
	localparam int SYM_W           = 8;
	localparam int CNT_W           = 9;
	localparam int VBITS_W         = 4;
	localparam int BYTE_W          = 8;
	localparam int MAX_SYMBOLS_DEF = 256;
	localparam int CNT_MIN         = 2;

	// Item kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_CODE = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [NODE_W-1:0]  node_index;
		logic [NODE_W-1:0]  left_index;
		logic [NODE_W-1:0]  right_index;
		logic [SYM_W-1:0]   leaf_value;
		logic [BYTE_W-1:0]  code_byte;
		logic [VBITS_W-1:0] valid_bits;
		logic               final_byte;
	} in_item_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             run_last;
		logic             stream_end;
	} out_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] symbol_count;
	} cfg_item_t;

	typedef struct packed {
		logic [NODE_W-1:0] left;
		logic [NODE_W-1:0] right;
	} node_ent_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROOT_RD,
		S_ROOT_WR,
		S_START,
		S_WALK,
		S_FLUSH
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic cfg_wr;
		logic load;
		logic take_byte;
		logic root_rd;
		logic root_wr;
		logic start;
		logic step;
		logic last_check;
		logic flush;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic leaf_hit;
		logic hold_v;
		logic out_free;
		logic bits_done;
	} dp_sts_t;

endpackage

/* rtl/hufd_stream_if.sv */
// Valid/ready channel carrying one word of a payload type.
// Used for the input, result and configuration channels; payload types come from hufd_pkg.
interface hufd_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* rtl/hufd_ctrl.sv */
// Controller state machine of the Huffman tree-walk decoder.
// Depends on hufd_pkg; drives hufd_datapath through ctl_cmd_t.
module hufd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_kind,
	input  logic               cfg_valid,
	input  hufd_pkg::dp_sts_t  sts,
	output logic               in_ready,
	output hufd_pkg::ctl_cmd_t cmd
);
	import hufd_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   stall;
	logic   in_fire;

	// Hold the walk while a finished symbol cannot be handed on
	assign stall   = sts.leaf_hit && sts.hold_v && !sts.out_free;
	assign in_fire = in_valid && in_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && in_kind == KIND_CODE) state_d = S_START;
			end
			S_ROOT_RD: state_d = S_ROOT_WR;
			S_ROOT_WR: state_d = S_IDLE;
			S_START:   state_d = S_WALK;
			S_WALK: begin
				if (!stall && sts.bits_done) state_d = S_FLUSH;
			end
			S_FLUSH: begin
				if (!sts.hold_v || sts.out_free) state_d = S_IDLE;
			end
			default:   state_d = S_IDLE;
		endcase
		// a new symbol count always refetches the root entry
		if (cfg_valid) state_d = S_ROOT_RD;
	end

	// Outputs
	always_comb begin
		in_ready       = 1'b0;
		cmd            = '0;
		cmd.cfg_wr     = cfg_valid;
		unique case (state_q)
			S_IDLE: begin
				in_ready      = !cfg_valid;
				cmd.load      = in_fire && in_kind == KIND_LOAD;
				cmd.take_byte = in_fire && in_kind == KIND_CODE;
			end
			S_ROOT_RD: cmd.root_rd = 1'b1;
			S_ROOT_WR: cmd.root_wr = 1'b1;
			S_START:   cmd.start = 1'b1;
			S_WALK: begin
				cmd.step       = !stall && !sts.bits_done;
				cmd.last_check = !stall && sts.bits_done;
			end
			S_FLUSH:   cmd.flush = !sts.hold_v || sts.out_free;
			default:   in_ready = 1'b0;
		endcase
	end

endmodule

/* rtl/hufd_datapath.sv */
// Datapath of the Huffman tree-walk decoder: node and symbol memories,
// root cache, bit shifter, symbol hold stage and result register. Depends on hufd_pkg.
module hufd_datapath #(
	parameter int MAX_SYMBOLS = hufd_pkg::MAX_SYMBOLS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hufd_pkg::ctl_cmd_t  cmd,
	input  hufd_pkg::in_item_t  in_data,
	input  hufd_pkg::cfg_item_t cfg_data,
	input  logic                out_ready,
	output logic                out_valid,
	output hufd_pkg::out_item_t out_data,
	output hufd_pkg::dp_sts_t   sts
);
	import hufd_pkg::*;

	localparam int SYM_AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
	localparam logic [NODE_W-1:0] MAX_NODE = NODE_W'(MAX_SYMBOLS);

	// Memories
	node_ent_t        node_mem [NODE_DEPTH];
	logic [SYM_W-1:0] sym_mem  [MAX_SYMBOLS];

	// Registers
	logic [CNT_W-1:0]   count_q;
	logic [NODE_W-1:0]  cur_idx_q;
	node_ent_t          root_ent_q;
	node_ent_t          rd_q;
	logic [SYM_W-1:0]   sym_q;
	logic               rng_q;
	logic               rd_child_q;
	logic [BYTE_W-1:0]  shift_q;
	logic [VBITS_W-1:0] nbits_q;
	logic [VBITS_W-1:0] bit_q;
	logic               final_q;
	logic               hold_v_q;
	logic [SYM_W-1:0]   hold_sym_q;
	logic               out_valid_q;
	out_item_t          out_q;

	// Combinational
	logic [CNT_W-1:0]   new_cnt;
	logic [NODE_W-1:0]  root;
	logic [NODE_W-1:0]  new_root;
	logic               leaf_hit;
	node_ent_t          cur_ent;
	logic [NODE_W-1:0]  child;
	logic               rd_en;
	logic [NODE_W-1:0]  rd_addr;
	logic               rd_in_rng;
	logic [SYM_W-1:0]   leaf_sym;
	logic               push_mid;
	logic               push_end;
	logic               out_free;
	logic               ld_leaf;
	logic [VBITS_W-1:0] nbits_in;

	// Clamp the written count and derive the roots
	always_comb begin
		new_cnt = cfg_data.symbol_count;
		if (new_cnt < CNT_W'(CNT_MIN)) new_cnt = CNT_W'(CNT_MIN);
		if (new_cnt > CNT_W'(MAX_SYMBOLS)) new_cnt = CNT_W'(MAX_SYMBOLS);
	end
	assign root     = NODE_W'(({1'b0, count_q} << 1) - (CNT_W+1)'(1));
	assign new_root = NODE_W'(({1'b0, new_cnt} << 1) - (CNT_W+1)'(1));

	// Step one bit down the tree; a leaf just read restarts from the root
	assign leaf_hit = rd_child_q && (rd_q.left == '0 || rd_q.right == '0);
	assign cur_ent  = leaf_hit ? root_ent_q : rd_q;
	assign child    = shift_q[BYTE_W-1] ? cur_ent.right : cur_ent.left;
	assign leaf_sym = rng_q ? sym_q : '0;

	// Read address select
	always_comb begin
		rd_en   = cmd.root_rd || cmd.start || cmd.step;
		rd_addr = child;
		if (cmd.root_rd) rd_addr = root;
		else if (cmd.start) rd_addr = cur_idx_q;
	end
	assign rd_in_rng = rd_addr != '0 && rd_addr <= MAX_NODE;

	assign ld_leaf = (in_data.left_index == '0 || in_data.right_index == '0)
		&& in_data.node_index != '0 && in_data.node_index <= MAX_NODE;

	// Node and symbol memories
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			node_mem[in_data.node_index] <= '{left: in_data.left_index,
				right: in_data.right_index};
			if (ld_leaf) begin
				sym_mem[SYM_AW'(in_data.node_index - NODE_W'(1))] <= in_data.leaf_value;
			end
		end
		if (rd_en) begin
			rd_q  <= node_mem[rd_addr];
			sym_q <= sym_mem[SYM_AW'(rd_addr - NODE_W'(1))];
			rng_q <= rd_in_rng;
		end
	end

	// Root cache: follow loads into the root, refetch on a new count
	always_ff @(posedge clk) begin
		if (cmd.root_wr) begin
			root_ent_q <= rd_q;
		end else if (cmd.load && in_data.node_index == root) begin
			root_ent_q <= '{left: in_data.left_index, right: in_data.right_index};
		end
	end

	// Symbol count and walk position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= CNT_W'(CNT_MIN);
			cur_idx_q  <= NODE_W'(2 * CNT_MIN - 1);
			rd_child_q <= 1'b0;
			bit_q      <= '0;
		end else begin
			if (cmd.cfg_wr) begin
				count_q   <= new_cnt;
				cur_idx_q <= new_root;
			end else if (cmd.step) begin
				cur_idx_q <= child;
			end else if (cmd.last_check && (leaf_hit || final_q)) begin
				cur_idx_q <= root;
			end
			if (cmd.start) rd_child_q <= 1'b0;
			else if (cmd.step) rd_child_q <= 1'b1;
			if (cmd.take_byte) bit_q <= '0;
			else if (cmd.step) bit_q <= bit_q + VBITS_W'(1);
		end
	end

	// Code word capture and shift, most significant bit first
	always_comb begin
		nbits_in = VBITS_W'(BYTE_W);
		if (in_data.final_byte && in_data.valid_bits != '0
			&& in_data.valid_bits <= VBITS_W'(BYTE_W)) begin
			nbits_in = in_data.valid_bits;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_byte) begin
			shift_q <= in_data.code_byte;
			nbits_q <= nbits_in;
			final_q <= in_data.final_byte;
		end else if (cmd.step) begin
			shift_q <= shift_q << 1;
		end
	end

	// Hold one symbol back so the last of a word can be marked
	assign out_free = !out_valid_q || out_ready;
	assign push_mid = (cmd.step || cmd.last_check) && leaf_hit && hold_v_q;
	assign push_end = cmd.flush && hold_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((cmd.step || cmd.last_check) && leaf_hit) hold_v_q <= 1'b1;
			else if (cmd.flush) hold_v_q <= 1'b0;
			if (push_mid || push_end) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((cmd.step || cmd.last_check) && leaf_hit) hold_sym_q <= leaf_sym;
		if (push_mid || push_end) begin
			out_q.symbol     <= hold_sym_q;
			out_q.run_last   <= push_end;
			out_q.stream_end <= push_end && final_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_data      = out_q;
	assign sts.leaf_hit  = leaf_hit;
	assign sts.hold_v    = hold_v_q;
	assign sts.out_free  = out_free;
	assign sts.bits_done = bit_q == nbits_q;

endmodule

/* rtl/huffman_tree_decoder_top.sv */
// Huffman tree-walk decoder, top level.
// Channels: in_item takes one word per item: kind 0 loads one tree node (children and leaf
// symbol), kind 1 gives a code byte decoded most significant bit first. out_item gives one
// word per decoded symbol with run_last on the last symbol of a byte and stream_end on the
// last symbol of a final byte. cfg takes the symbol count; the root is node 2*count-1.
// Load words are taken back to back. A code byte goes through accept, a read of the current
// node, one dependent node-memory read per code bit, one leaf check and the release of the
// held symbol; the node memory read port, read once per bit, bounds the byte rate. A symbol
// is held until the leaf check of the next symbol of its byte or the release step and is in
// out_item the cycle after that.
// A count write refetches the root entry (read, then write); in_item is not ready meanwhile.
// Reset: symbol count 2, walk at node 3, no result pending. The tree memories are not
// cleared; every node reached must have been loaded first.
// Stall: a full result register with out_item not ready holds the walk in place when a symbol
// is to be handed on; nothing is lost and the next word is not taken until the byte is done.
// Depends on hufd_pkg, hufd_stream_if, hufd_ctrl and hufd_datapath.
module huffman_tree_decoder_top #(
	parameter int MAX_SYMBOLS = hufd_pkg::MAX_SYMBOLS_DEF
) (
	input logic     clk,
	input logic     arst_n,
	hufd_stream_if.sink   in_item,
	hufd_stream_if.source out_item,
	hufd_stream_if.sink   cfg
);
	import hufd_pkg::*;

	ctl_cmd_t  cmd;
	dp_sts_t   sts;
	in_item_t  in_data;
	cfg_item_t cfg_data;
	out_item_t out_data;
	logic      in_ready;
	logic      out_valid;

	assign in_data  = in_item.data;
	assign cfg_data = cfg.data;

	// Count writes are always taken
	assign cfg.ready     = 1'b1;
	assign in_item.ready = in_ready;

	hufd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_item.valid),
		.in_kind  (in_data.kind),
		.cfg_valid(cfg.valid),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	hufd_datapath #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.cfg_data (cfg_data),
		.out_ready(out_item.ready),
		.out_valid(out_valid),
		.out_data (out_data),
		.sts      (sts)
	);

	assign out_item.valid = out_valid;
	assign out_item.data  = out_data;

endmodule

/* bench/huffman_tree_decoder_top_tb.sv */
`timescale 1ns / 100ps
// Testbench for huffman_tree_decoder_top: loads random code trees, streams code bytes through
// them under random idling and stalls, and checks every symbol word against a tree walker.
// Depends on hufd_pkg, hufd_stream_if and the decoder RTL.
module huffman_tree_decoder_top_tb;
	import hufd_pkg::*;

	localparam int TIMEOUT_CYCLES = 400000;
	localparam int SETTLE_CYCLES  = 24;
	localparam int MAX_REPORTS    = 60;

	// Tree walker: mirrors the node tables and the walk position, queues expected symbol words
	class symbol_scoreboard;
		logic [NODE_W-1:0] left_kid [NODE_DEPTH];
		logic [NODE_W-1:0] right_kid [NODE_DEPTH];
		logic [SYM_W-1:0]  leaf_sym [MAX_SYMBOLS_DEF];
		int unsigned       sym_count;
		logic [NODE_W-1:0] walk_node;
		out_item_t         symbol_q[$];
		int                errors;

		function new();
			sym_count = CNT_MIN;
			walk_node = root_node();
			errors = 0;
		endfunction

		function logic [NODE_W-1:0] root_node();
			return NODE_W'(2 * sym_count - 1);
		endfunction

		// Clamp the count and restart the walk at the new root
		function void set_count(logic [CNT_W-1:0] raw);
			if (raw < CNT_MIN) begin
				sym_count = CNT_MIN;
			end else if (raw > MAX_SYMBOLS_DEF) begin
				sym_count = MAX_SYMBOLS_DEF;
			end else begin
				sym_count = raw;
			end
			walk_node = root_node();
		endfunction

		function void note_word(in_item_t w);
			int                nbits;
			logic [NODE_W-1:0] n;
			out_item_t         held;
			bit                have;
			// Node write: symbol kept only for a leaf inside the symbol range
			if (w.kind == KIND_LOAD) begin
				left_kid[w.node_index] = w.left_index;
				right_kid[w.node_index] = w.right_index;
				if ((w.left_index == 0 || w.right_index == 0) && w.node_index >= 1 &&
				    w.node_index <= MAX_SYMBOLS_DEF)
					leaf_sym[w.node_index - 1] = w.leaf_value;
				return;
			end
			nbits = (w.final_byte && w.valid_bits >= 1 && w.valid_bits <= 8) ? w.valid_bits : 8;
			n = walk_node;
			have = 1'b0;
			// Walk the bits, most significant first; hold the latest symbol to flag it last
			for (int i = 0; i < nbits; i++) begin
				n = w.code_byte[BYTE_W-1-i] ? right_kid[n] : left_kid[n];
				if (left_kid[n] == 0 || right_kid[n] == 0) begin
					if (have)
						symbol_q.push_back(held);
					held.symbol = (n >= 1 && n <= MAX_SYMBOLS_DEF) ? leaf_sym[n-1] : '0;
					held.run_last = 1'b0;
					held.stream_end = 1'b0;
					have = 1'b1;
					n = root_node();
				end
			end
			if (have) begin
				held.run_last = 1'b1;
				held.stream_end = w.final_byte;
				symbol_q.push_back(held);
			end
			// A final byte drops any partial code
			walk_node = w.final_byte ? root_node() : n;
		endfunction

		function void check_word(out_item_t got);
			out_item_t want;
			if (symbol_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: symbol word with none expected: expected none actual %h",
					         $time, got);
				return;
			end
			want = symbol_q.pop_front();
			if (got.symbol !== want.symbol) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: symbol expected %02h actual %02h",
					         $time, want.symbol, got.symbol);
			end
			if (got.run_last !== want.run_last) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: run_last expected %b actual %b",
					         $time, want.run_last, got.run_last);
			end
			if (got.stream_end !== want.stream_end) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: stream_end expected %b actual %b",
					         $time, want.stream_end, got.stream_end);
			end
		endfunction

		function int pending();
			return symbol_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hufd_stream_if #(.T(in_item_t))  in_ch ();
	hufd_stream_if #(.T(out_item_t)) out_ch ();
	hufd_stream_if #(.T(cfg_item_t)) cfg_ch ();

	huffman_tree_decoder_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_item(in_ch),
		.out_item(out_ch),
		.cfg(cfg_ch)
	);

	symbol_scoreboard sb = new();

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycles = 0;

	// Shape of the tree in use, kept for reloads and child swaps
	int leaves[$];
	int inner[$];
	int kid_l[NODE_DEPTH];
	int kid_r[NODE_DEPTH];
	int far_node;
	int tree_n;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stall the result channel at random
	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Feed every handshake to the scoreboard
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				sb.set_count(cfg_ch.data.symbol_count);
			if (in_ch.valid && in_ch.ready)
				sb.note_word(in_ch.data);
			if (out_ch.valid && out_ch.ready)
				sb.check_word(out_ch.data);
		end
	end

	// Drop the run if it hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == TIMEOUT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Present one word; leave valid high after acceptance for the next caller
	task automatic send_word(in_item_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= w;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic send_load(int node, int l, int r);
		in_item_t w;
		w.kind = KIND_LOAD;
		w.node_index = NODE_W'(node);
		w.left_index = NODE_W'(l);
		w.right_index = NODE_W'(r);
		w.leaf_value = SYM_W'($urandom_range(255));
		w.code_byte = BYTE_W'($urandom_range(255));
		w.valid_bits = VBITS_W'($urandom_range(15));
		w.final_byte = 1'($urandom_range(1));
		send_word(w);
	endtask

	task automatic send_code(int code, int vbits, bit fin);
		in_item_t w;
		w.kind = KIND_CODE;
		w.node_index = NODE_W'($urandom_range(NODE_DEPTH-1));
		w.left_index = NODE_W'($urandom_range(NODE_DEPTH-1));
		w.right_index = NODE_W'($urandom_range(NODE_DEPTH-1));
		w.leaf_value = SYM_W'($urandom_range(255));
		w.code_byte = BYTE_W'(code);
		w.valid_bits = VBITS_W'(vbits);
		w.final_byte = fin;
		send_word(w);
	endtask

	// A leaf needs only one zero child
	task automatic send_leaf(int node);
		case ($urandom_range(2))
			0: send_load(node, 0, 0);
			1: send_load(node, 0, $urandom_range(NODE_DEPTH-1, 1));
			default: send_load(node, $urandom_range(NODE_DEPTH-1, 1), 0);
		endcase
	endtask

	// Build a random full tree: leaves 1..n, inner nodes just below the root 2*cnt-1,
	// root last; optionally move one leaf above the symbol range
	task automatic load_tree(int n, int cnt, bit far);
		int pool[$];
		int a;
		int b;
		int i;
		int next;
		leaves = {};
		inner = {};
		far_node = 0;
		tree_n = cnt;
		for (i = 1; i <= n; i++)
			leaves.push_back(i);
		if (far && cnt < MAX_SYMBOLS_DEF) begin
			far_node = $urandom_range(NODE_DEPTH-1, (2 * cnt > 257) ? 2 * cnt : 257);
			leaves[$urandom_range(n-1)] = far_node;
		end
		foreach (leaves[k])
			send_leaf(leaves[k]);
		pool = leaves;
		next = 2 * cnt - n + 1;
		while (pool.size() > 1) begin
			i = $urandom_range(pool.size()-1);
			a = pool[i];
			pool.delete(i);
			i = $urandom_range(pool.size()-1);
			b = pool[i];
			pool.delete(i);
			kid_l[next] = a;
			kid_r[next] = b;
			send_load(next, a, b);
			inner.push_back(next);
			pool.push_back(next);
			next++;
		end
	endtask

	// Rewrite the tree mid-stream: new leaf symbol, swapped children, or a stray node
	task automatic disturb_tree();
		int pick;
		int node;
		int tmp;
		pick = $urandom_range(2);
		if (pick == 2 && 2 * tree_n <= NODE_DEPTH - 2) begin
			do node = $urandom_range(NODE_DEPTH-1, 2 * tree_n); while (node == far_node);
			send_load(node, $urandom_range(NODE_DEPTH-1), $urandom_range(NODE_DEPTH-1));
		end else if (pick == 1) begin
			node = inner[$urandom_range(inner.size()-1)];
			tmp = kid_l[node];
			kid_l[node] = kid_r[node];
			kid_r[node] = tmp;
			send_load(node, kid_l[node], kid_r[node]);
		end else begin
			send_leaf(leaves[$urandom_range(leaves.size()-1)]);
		end
	endtask

	// Wait for all symbols, then let a byte with no symbol finish
	task automatic wait_idle();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(int raw);
		cfg_item_t c;
		c.symbol_count = CNT_W'(raw);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= c;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// New tree, then the count while the block is idle
	task automatic start_phase(int raw, int n, bit far, int idle_pct, int stall_pct);
		int cnt;
		cnt = (raw < CNT_MIN) ? CNT_MIN : (raw > MAX_SYMBOLS_DEF) ? MAX_SYMBOLS_DEF : raw;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		in_ch.valid <= 1'b0;
		wait_idle();
		load_tree(n, cnt, far);
		in_ch.valid <= 1'b0;
		wait_idle();
		write_count(raw);
	endtask

	task automatic random_stream(int nbytes);
		int sent;
		sent = 0;
		while (sent < nbytes) begin
			if ($urandom_range(99) < 12) begin
				disturb_tree();
			end else begin
				send_code($urandom_range(255), $urandom_range(15), $urandom_range(99) < 15);
				sent++;
			end
		end
	endtask

	initial begin
		int r1;
		int r2;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		out_ch.ready = 1'b0;
		r1 = $urandom_range(10, 4);
		r2 = $urandom_range(20, 11);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Three symbols, one leaf above the symbol range: full bytes, partial codes,
		// codes across bytes, final bytes with and without a symbol, every valid-bit form
		start_phase(3, 3, 1'b1, 0, 0);
		send_code(8'h00, 0, 1'b0);
		send_code(8'hFF, 5, 1'b0);
		send_code(8'h80, 1, 1'b1);
		send_code(8'h00, 1, 1'b1);
		send_code(8'h5A, 0, 1'b1);
		send_code(8'hA5, 15, 1'b1);
		send_code(8'h3C, 9, 1'b1);
		send_code(8'h01, 3, 1'b0);
		send_code(8'h7F, 8, 1'b1);
		send_code(8'hC3, 2, 1'b1);
		send_code(8'h96, 0, 1'b0);

		// Count below the minimum: every bit ends a code
		start_phase(0, 2, 1'b0, 0, 0);
		send_code(8'h00, 0, 1'b0);
		send_code(8'hFF, 8, 1'b1);
		send_code(8'hA5, 4, 1'b1);

		// Random streams over several counts and idling patterns; the count above the
		// maximum puts the root at the top node with a small tree under it
		start_phase(511, 6, 1'b0, 0, 0);
		random_stream(20);
		start_phase(r1, r1, 1'b1, 60, 0);
		random_stream(20);
		start_phase(1, 2, 1'b1, 0, 60);
		random_stream(20);
		start_phase(r2, r2, 1'b1, 27, 27);
		random_stream(20);

		in_ch.valid <= 1'b0;
		wait_idle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

/* sim.f */
rtl/hufd_pkg.sv
rtl/hufd_stream_if.sv
rtl/hufd_ctrl.sv
rtl/hufd_datapath.sv
rtl/huffman_tree_decoder_top.sv
bench/huffman_tree_decoder_top_tb.sv
